// ===== rtl/core/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared types and constants of the vertex transform and projection core.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned QBits    = 19;
  localparam int unsigned DivLat   = QBits + 2;
  localparam int unsigned NumW     = 56;
  localparam int unsigned DenW     = 45;
  localparam int          Focal    = 300;
  localparam int          MinDepth = 256;

  typedef enum logic [2:0] {
    RegObjCos = 3'd0,
    RegObjSin = 3'd1,
    RegCamCos = 3'd2,
    RegCamSin = 3'd3,
    RegScale  = 3'd4,
    RegOffset = 3'd5,
    RegCenter = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] obj_cos;
    logic [47:0] obj_sin;
    logic [47:0] cam_cos;
    logic [47:0] cam_sin;
    logic [47:0] scale;
    logic [62:0] offset;
    logic [31:0] center;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

endpackage

// ===== rtl/core/vertex_transform_project_core.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and projection core
// Scales, rotates, offsets and rotates each vertex, then projects it.
//
//   Channel   Handshake          Payload
//   vertex    start / busy       vert_x_i, vert_y_i, vert_z_i, last_in_i
//   result    done_o strobe      screen_x_o, screen_y_o, view_depth_o, last_out_o
//   config    APB psel/penable   paddr, pwdata, prdata (64-bit registers at 8*i)
//
// A vertex is taken in every cycle and passes the scale register, six
// two-stage rotation steps split by the offset register, the projection register,
// the 19-stage restoring dividers and the output register. Reset clears only
// the valid bits and the registers; there is no clearing pass. busy stays low,
// and the receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module vertex_transform_project_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] vert_x_i,
  input  logic signed [23:0] vert_y_i,
  input  logic signed [23:0] vert_z_i,
  input  logic               last_in_i,
  output logic               done_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic signed [23:0] view_depth_o,
  output logic               last_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned DL  = vtp_pkg::DivLat;
  localparam int unsigned Lat = 16 + DL;
  localparam int unsigned QW  = vtp_pkg::QBits + 2;

  vtp_pkg::cfg_t cfg;
  vtp_pkg::ctl_t ctl_in, ctl0_q, ctl1, ctl2, ctl3, ctl4_q, ctl5, ctl6, ctl7;

  logic signed [39:0] sx_q, sy_q, sz_q;
  logic signed [33:0] x1, y1, z1;
  logic signed [35:0] x2, y2, z2;
  logic signed [37:0] x3, y3, z3;
  logic signed [38:0] x4_q, y4_q, z4_q;
  logic signed [40:0] x5, y5, z5;
  logic signed [42:0] x6, y6, z6;
  logic signed [44:0] x7, y7, z7;

  logic                              proj_vld_q;
  logic signed [vtp_pkg::NumW-1:0]   nx_q, ny_q;
  logic        [vtp_pkg::DenW-1:0]   zc_q;
  logic signed [36:0]                zt;
  logic signed [23:0]                dep_d;
  logic signed [23:0]                dep_pipe_q  [DL+1];
  logic                              last_pipe_q [DL+1];

  logic                  divx_vld;
  logic                  divy_vld;
  logic signed [QW-1:0]  qx, qy;
  logic                  nzx, nzy;

  logic                  done_q;
  logic signed [15:0]    scr_x_q, scr_y_q;
  logic signed [23:0]    dep_q;
  logic                  last_q;

  function automatic logic signed [15:0] place_sat(logic signed [QW-1:0] fq, logic nz,
                                                   logic [15:0] ctr);
    logic signed [QW:0] v;
    logic signed [QW:0] t;
    v = (QW+1)'(fq) + (QW+1)'($signed({1'b0, ctr}));
    t = (v < 0 && nz) ? v + (QW+1)'(1) : v;
    if (t > (QW+1)'(32767)) begin
      return 16'sh7fff;
    end else if (t < -(QW+1)'(32768)) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  vtp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy        = 1'b0;
  assign ctl_in.vld  = start;
  assign ctl_in.last = last_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl_in;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= 40'(vert_x_i) * 40'($signed(cfg.scale[15:0]));
    sy_q <= 40'(vert_y_i) * 40'($signed(cfg.scale[31:16]));
    sz_q <= 40'(vert_z_i) * 40'($signed(cfg.scale[47:32]));
  end

  vtp_rot #(.W(32)) u_obj_x (
    .clk_i, .rst_ni, .ctl_i(ctl0_q),
    .a_i(sy_q[39:8]), .b_i(sz_q[39:8]), .p_i(sx_q[39:8]),
    .c_i($signed(cfg.obj_cos[15:0])), .s_i($signed(cfg.obj_sin[15:0])),
    .ctl_o(ctl1), .a_o(y1), .b_o(z1), .p_o(x1)
  );

  vtp_rot #(.W(34)) u_obj_y (
    .clk_i, .rst_ni, .ctl_i(ctl1),
    .a_i(z1), .b_i(x1), .p_i(y1),
    .c_i($signed(cfg.obj_cos[31:16])), .s_i($signed(cfg.obj_sin[31:16])),
    .ctl_o(ctl2), .a_o(z2), .b_o(x2), .p_o(y2)
  );

  vtp_rot #(.W(36)) u_obj_z (
    .clk_i, .rst_ni, .ctl_i(ctl2),
    .a_i(x2), .b_i(y2), .p_i(z2),
    .c_i($signed(cfg.obj_cos[47:32])), .s_i($signed(cfg.obj_sin[47:32])),
    .ctl_o(ctl3), .a_o(x3), .b_o(y3), .p_o(z3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl3;
    end
  end

  always_ff @(posedge clk_i) begin
    x4_q <= 39'(x3) + 39'($signed(cfg.offset[20:0]));
    y4_q <= 39'(y3) + 39'($signed(cfg.offset[41:21]));
    z4_q <= 39'(z3) + 39'($signed(cfg.offset[62:42]));
  end

  vtp_rot #(.W(39)) u_cam_x (
    .clk_i, .rst_ni, .ctl_i(ctl4_q),
    .a_i(y4_q), .b_i(z4_q), .p_i(x4_q),
    .c_i($signed(cfg.cam_cos[15:0])), .s_i($signed(cfg.cam_sin[15:0])),
    .ctl_o(ctl5), .a_o(y5), .b_o(z5), .p_o(x5)
  );

  vtp_rot #(.W(41)) u_cam_y (
    .clk_i, .rst_ni, .ctl_i(ctl5),
    .a_i(z5), .b_i(x5), .p_i(y5),
    .c_i($signed(cfg.cam_cos[31:16])), .s_i($signed(cfg.cam_sin[31:16])),
    .ctl_o(ctl6), .a_o(z6), .b_o(x6), .p_o(y6)
  );

  vtp_rot #(.W(43)) u_cam_z (
    .clk_i, .rst_ni, .ctl_i(ctl6),
    .a_i(x6), .b_i(y6), .p_i(z6),
    .c_i($signed(cfg.cam_cos[47:32])), .s_i($signed(cfg.cam_sin[47:32])),
    .ctl_o(ctl7), .a_o(x7), .b_o(y7), .p_o(z7)
  );

  always_comb begin
    zt = 37'(z7 >>> 8) + 37'((z7 < 0 && z7[7:0] != 8'd0) ? 1 : 0);
    if (zt > 37'sd8388607) begin
      dep_d = 24'sh7fffff;
    end else if (zt < -37'sd8388608) begin
      dep_d = 24'sh800000;
    end else begin
      dep_d = zt[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_vld_q <= 1'b0;
    end else begin
      proj_vld_q <= ctl7.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= vtp_pkg::NumW'(x7) * vtp_pkg::NumW'(vtp_pkg::Focal);
    ny_q <= (-vtp_pkg::NumW'(y7)) * vtp_pkg::NumW'(vtp_pkg::Focal);
    zc_q <= (z7 < 45'(vtp_pkg::MinDepth)) ? vtp_pkg::DenW'(vtp_pkg::MinDepth) : z7;
    dep_pipe_q[0]  <= dep_d;
    last_pipe_q[0] <= ctl7.last;
  end

  for (genvar i = 1; i < DL + 1; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      dep_pipe_q[i]  <= dep_pipe_q[i-1];
      last_pipe_q[i] <= last_pipe_q[i-1];
    end
  end

  vtp_div u_div_x (
    .clk_i, .rst_ni, .vld_i(proj_vld_q), .n_i(nx_q), .d_i(zc_q),
    .vld_o(divx_vld), .q_o(qx), .nz_o(nzx)
  );

  vtp_div u_div_y (
    .clk_i, .rst_ni, .vld_i(proj_vld_q), .n_i(ny_q), .d_i(zc_q),
    .vld_o(divy_vld), .q_o(qy), .nz_o(nzy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= divx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    scr_x_q <= place_sat(qx, nzx, cfg.center[15:0]);
    scr_y_q <= place_sat(qy, nzy, cfg.center[31:16]);
    dep_q   <= dep_pipe_q[DL];
    last_q  <= last_pipe_q[DL];
  end

  assign done_o       = done_q;
  assign screen_x_o   = scr_x_q;
  assign screen_y_o   = scr_y_q;
  assign view_depth_o = dep_q;
  assign last_out_o   = last_q;

`ifndef SYNTH
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("accepted word produced no result");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without an accepted word");
  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_in_i, Lat)))
    else $error("last flag out of order");
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_vld == divy_vld)
    else $error("dividers out of step");
`endif

endmodule

// ===== rtl/core/vtp_regs.sv =====
// ----------------------------------------------------------------------------
// Vertex transform configuration registers
// APB register file holding rotation, scale, offset and center settings.
// ----------------------------------------------------------------------------
module vtp_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output vtp_pkg::cfg_t      cfg_o
);

  vtp_pkg::cfg_t     cfg_q;
  vtp_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = vtp_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obj_cos <= 48'h4000_4000_4000;
      cfg_q.obj_sin <= '0;
      cfg_q.cam_cos <= 48'h4000_4000_4000;
      cfg_q.cam_sin <= '0;
      cfg_q.scale   <= 48'h0100_0100_0100;
      cfg_q.offset  <= '0;
      cfg_q.center  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        vtp_pkg::RegObjCos: cfg_q.obj_cos <= pwdata[47:0];
        vtp_pkg::RegObjSin: cfg_q.obj_sin <= pwdata[47:0];
        vtp_pkg::RegCamCos: cfg_q.cam_cos <= pwdata[47:0];
        vtp_pkg::RegCamSin: cfg_q.cam_sin <= pwdata[47:0];
        vtp_pkg::RegScale:  cfg_q.scale   <= pwdata[47:0];
        vtp_pkg::RegOffset: cfg_q.offset  <= pwdata[62:0];
        vtp_pkg::RegCenter: cfg_q.center  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vtp_pkg::RegObjCos: prdata = 64'(cfg_q.obj_cos);
      vtp_pkg::RegObjSin: prdata = 64'(cfg_q.obj_sin);
      vtp_pkg::RegCamCos: prdata = 64'(cfg_q.cam_cos);
      vtp_pkg::RegCamSin: prdata = 64'(cfg_q.cam_sin);
      vtp_pkg::RegScale:  prdata = 64'(cfg_q.scale);
      vtp_pkg::RegOffset: prdata = 64'(cfg_q.offset);
      vtp_pkg::RegCenter: prdata = 64'(cfg_q.center);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/vtp_rot.sv =====
// ----------------------------------------------------------------------------
// Vertex transform rotation step
// Two-stage rotation of one coordinate pair, with a third coordinate carried.
// ----------------------------------------------------------------------------
module vtp_rot #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtp_pkg::ctl_t       ctl_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] p_i,
  input  logic signed [15:0]  c_i,
  input  logic signed [15:0]  s_i,
  output vtp_pkg::ctl_t       ctl_o,
  output logic signed [W+1:0] a_o,
  output logic signed [W+1:0] b_o,
  output logic signed [W+1:0] p_o
);

  vtp_pkg::ctl_t        ctl1_q, ctl2_q;
  logic signed [W+15:0] ac_q, bs_q, as_q, bc_q;
  logic signed [W-1:0]  p1_q;
  logic signed [W+16:0] diff_a, sum_b;
  logic signed [W+1:0]  a_q, b_q, p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q <= (W+16)'(a_i) * (W+16)'(c_i);
    bs_q <= (W+16)'(b_i) * (W+16)'(s_i);
    as_q <= (W+16)'(a_i) * (W+16)'(s_i);
    bc_q <= (W+16)'(b_i) * (W+16)'(c_i);
    p1_q <= p_i;
  end

  assign diff_a = (W+17)'(ac_q) - (W+17)'(bs_q);
  assign sum_b  = (W+17)'(as_q) + (W+17)'(bc_q);

  always_ff @(posedge clk_i) begin
    a_q <= diff_a[W+15:14];
    b_q <= sum_b[W+15:14];
    p_q <= (W+2)'(p1_q);
  end

  assign ctl_o = ctl2_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign p_o   = p_q;

endmodule

// ===== rtl/core/vtp_div.sv =====
// ----------------------------------------------------------------------------
// Vertex transform divider
// Pipelined restoring divider giving a floor quotient, clamped in magnitude,
// and a flag for a nonzero remainder. One quotient bit per stage.
// ----------------------------------------------------------------------------
module vtp_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic signed [vtp_pkg::NumW-1:0]    n_i,
  input  logic        [vtp_pkg::DenW-1:0]    d_i,
  output logic                               vld_o,
  output logic signed [vtp_pkg::QBits+1:0]   q_o,
  output logic                               nz_o
);

  localparam int unsigned Q    = vtp_pkg::QBits;
  localparam int unsigned NW   = vtp_pkg::NumW;
  localparam int unsigned DW   = vtp_pkg::DenW;
  localparam int unsigned CmpW = DW + Q;

  logic [NW-1:0] rem_q [Q+1];
  logic [Q-1:0]  quo_q [Q+1];
  logic [DW-1:0] d_q   [Q+1];
  logic          neg_q [Q+1];
  logic          ovf_q [Q+1];
  logic          vld_q [Q+1];

  logic [NW-1:0]  abs_n;
  logic           neg_n;
  logic [Q-1:0]   qa;
  logic           nz;
  logic [Q+1:0]   mag;
  logic [Q+1:0]   q_d;
  logic           vld_out_q;
  logic [Q+1:0]   q_out_q;
  logic           nz_out_q;

  assign neg_n = n_i[NW-1];
  assign abs_n = neg_n ? NW'(-n_i) : NW'(n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= abs_n;
    quo_q[0] <= '0;
    d_q[0]   <= d_i;
    neg_q[0] <= neg_n;
    ovf_q[0] <= CmpW'(abs_n) >= (CmpW'(d_i) << Q);
  end

  for (genvar k = 0; k < Q; k++) begin : g_bit
    logic [CmpW-1:0] dsh;
    logic            ge;

    assign dsh = CmpW'(d_q[k]) << (Q - 1 - k);
    assign ge  = CmpW'(rem_q[k]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? rem_q[k] - dsh[NW-1:0] : rem_q[k];
      quo_q[k+1] <= {quo_q[k][Q-2:0], ge};
      d_q[k+1]   <= d_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  always_comb begin
    qa  = ovf_q[Q] ? '1 : quo_q[Q];
    nz  = ovf_q[Q] | (rem_q[Q] != '0);
    mag = (Q+2)'(qa) + (Q+2)'(nz);
    q_d = neg_q[Q] ? -mag : (Q+2)'(qa);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    q_out_q  <= q_d;
    nz_out_q <= nz;
  end

  assign vld_o = vld_out_q;
  assign q_o   = q_out_q;
  assign nz_o  = nz_out_q;

endmodule

// ===== tb/vertex_transform_project_core_test.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and projection core testbench
// Drives vertex words through the start/busy port with random gaps, programs
// the rotation, scale, offset and center registers over APB between phases,
// and compares every result word with an independent fixed-point prediction.
// ----------------------------------------------------------------------------
module vertex_transform_project_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        last;
  } vertex_t;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [23:0] depth;
    logic        last;
  } screen_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [23:0] vert_x_i;
  logic signed [23:0] vert_y_i;
  logic signed [23:0] vert_z_i;
  logic               last_in_i;
  logic               done_o;
  logic signed [15:0] screen_x_o;
  logic signed [15:0] screen_y_o;
  logic signed [23:0] view_depth_o;
  logic               last_out_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  vertex_transform_project_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .vert_x_i(vert_x_i), .vert_y_i(vert_y_i), .vert_z_i(vert_z_i),
    .last_in_i(last_in_i), .done_o(done_o), .screen_x_o(screen_x_o),
    .screen_y_o(screen_y_o), .view_depth_o(view_depth_o),
    .last_out_o(last_out_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vtp_pkg::cfg_t cfg;
  vertex_t pending_vertices[$];
  screen_t expected_screens[$];
  int      errors = 0;
  int      gap_left = 0;
  bit      hold_vertices = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("vertex_transform_project_core verification failed");
    $finish;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint lane(logic [47:0] r, int k);
    logic signed [15:0] l;
    l = r[16*k +: 16];
    return longint'(l);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate_axes(inout longint x, inout longint y, inout longint z,
                                      input logic [47:0] c, input logic [47:0] s);
    longint a, b;
    a = floor_shift(y * lane(c, 0) - z * lane(s, 0), 14);
    b = floor_shift(y * lane(s, 0) + z * lane(c, 0), 14);
    y = a;
    z = b;
    a = floor_shift(x * lane(c, 1) + z * lane(s, 1), 14);
    b = floor_shift(z * lane(c, 1) - x * lane(s, 1), 14);
    x = a;
    z = b;
    a = floor_shift(x * lane(c, 2) - y * lane(s, 2), 14);
    b = floor_shift(x * lane(s, 2) + y * lane(c, 2), 14);
    x = a;
    y = b;
  endfunction

  function automatic screen_t project_vertex(vertex_t v);
    longint x, y, z, zc, cx, cy;
    logic signed [20:0] ox, oy, oz;
    screen_t r;
    x = longint'($signed(v.x));
    y = longint'($signed(v.y));
    z = longint'($signed(v.z));
    x = floor_shift(x * lane(cfg.scale, 0), 8);
    y = floor_shift(y * lane(cfg.scale, 1), 8);
    z = floor_shift(z * lane(cfg.scale, 2), 8);
    rotate_axes(x, y, z, cfg.obj_cos, cfg.obj_sin);
    ox = cfg.offset[20:0];
    oy = cfg.offset[41:21];
    oz = cfg.offset[62:42];
    x += ox;
    y += oy;
    z += oz;
    rotate_axes(x, y, z, cfg.cam_cos, cfg.cam_sin);
    zc = z < vtp_pkg::MinDepth ? longint'(vtp_pkg::MinDepth) : z;
    cx = longint'(cfg.center[15:0]);
    cy = longint'(cfg.center[31:16]);
    r.sx = 16'(clip((x * vtp_pkg::Focal + cx * zc) / zc, -32768, 32767));
    r.sy = 16'(clip((-y * vtp_pkg::Focal + cy * zc) / zc, -32768, 32767));
    r.depth = 24'(clip(z / 256, -8388608, 8388607));
    r.last = v.last;
    return r;
  endfunction

  // Vertex driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      vert_x_i <= '0;
      vert_y_i <= '0;
      vert_z_i <= '0;
      last_in_i <= 1'b0;
      gap_left <= 0;
    end else begin
      automatic bit taken = start && !busy;
      automatic vertex_t v;
      if (taken) begin
        expected_screens.push_back(project_vertex({vert_x_i, vert_y_i, vert_z_i, last_in_i}));
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!hold_vertices && pending_vertices.size() > 0) begin
        v = pending_vertices.pop_front();
        vert_x_i <= v.x;
        vert_y_i <= v.y;
        vert_z_i <= v.z;
        last_in_i <= v.last;
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      automatic screen_t e;
      if (expected_screens.size() == 0) begin
        $display("%0t: unexpected result word sx=%0d sy=%0d depth=%0d",
                 $time, screen_x_o, screen_y_o, view_depth_o);
        errors++;
      end else begin
        e = expected_screens.pop_front();
        if (screen_x_o !== e.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, $signed(e.sx), screen_x_o);
          errors++;
        end
        if (screen_y_o !== e.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, $signed(e.sy), screen_y_o);
          errors++;
        end
        if (view_depth_o !== e.depth) begin
          $display("%0t: view_depth expected %0d actual %0d",
                   $time, $signed(e.depth), view_depth_o);
          errors++;
        end
        if (last_out_o !== e.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, e.last, last_out_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(vtp_pkg::reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      vtp_pkg::RegObjCos: cfg.obj_cos = value[47:0];
      vtp_pkg::RegObjSin: cfg.obj_sin = value[47:0];
      vtp_pkg::RegCamCos: cfg.cam_cos = value[47:0];
      vtp_pkg::RegCamSin: cfg.cam_sin = value[47:0];
      vtp_pkg::RegScale:  cfg.scale = value[47:0];
      vtp_pkg::RegOffset: cfg.offset = value[62:0];
      default:            cfg.center = value[31:0];
    endcase
  endtask

  task automatic drain;
    int guard;
    hold_vertices = 1'b0;
    while (pending_vertices.size() > 0 || start) @(posedge clk_i);
    hold_vertices = 1'b1;
    guard = 0;
    while (expected_screens.size() > 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic [15:0] unit_trig(bit is_cos);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r == 2) return 16'($urandom());
    if (is_cos) return 16'($urandom_range(0, 16384));
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [47:0] trig_triple(bit is_cos);
    return {unit_trig(is_cos), unit_trig(is_cos), unit_trig(is_cos)};
  endfunction

  function automatic logic [23:0] coord(int mode);
    if (mode == 0) return 24'($urandom());
    return 24'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  task automatic queue_random(int count, bit wild);
    vertex_t v;
    repeat (count) begin
      v.x = coord(wild ? 0 : $urandom_range(0, 4));
      v.y = coord(wild ? 0 : $urandom_range(0, 4));
      v.z = coord(wild ? 0 : $urandom_range(0, 4));
      v.last = 1'($urandom_range(0, 1));
      pending_vertices.push_back(v);
    end
  endtask

  initial begin
    vertex_t v;
    int extremes[5] = '{-8388608, 8388607, 0, -1, 256};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg = '{obj_cos: 48'h400040004000, obj_sin: '0, cam_cos: 48'h400040004000,
            cam_sin: '0, scale: 48'h010001000100, offset: '0, center: '0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, behind-camera depths, last flag both ways.
    foreach (extremes[i]) begin
      v = {24'(extremes[i]), 24'(extremes[(i + 1) % 5]), 24'(extremes[(i + 2) % 5]), 1'b1};
      pending_vertices.push_back(v);
      v = {24'(extremes[(i + 3) % 5]), 24'(extremes[i]), 24'(extremes[(i + 4) % 5]), 1'b0};
      pending_vertices.push_back(v);
    end
    pending_vertices.push_back({24'd100, -24'sd50, 24'd1000, 1'b0});
    pending_vertices.push_back({24'd100, 24'd50, -24'sd1000, 1'b1});
    drain();

    write_reg(vtp_pkg::RegCenter, 64'h0000_00f0_0140);
    write_reg(vtp_pkg::RegOffset, {1'b0, 21'd2560, 21'h1ffc00, 21'd512});
    write_reg(vtp_pkg::RegScale, 48'h0200_0080_0100);
    write_reg(vtp_pkg::RegObjCos, 48'h2d41_3b21_4000);
    write_reg(vtp_pkg::RegObjSin, 48'h2d41_187e_0000);
    write_reg(vtp_pkg::RegCamCos, 48'h4000_3b21_3b21);
    write_reg(vtp_pkg::RegCamSin, 48'h0000_e782_187e);
    pending_vertices.push_back({24'd0, 24'd0, 24'd0, 1'b1});
    pending_vertices.push_back({-24'sd8388608, 24'd8388607, -24'sd8388608, 1'b0});
    queue_random(10, 1'b1);
    drain();

    // Register extremes.
    write_reg(vtp_pkg::RegObjCos, 48'h8000_8000_8000);
    write_reg(vtp_pkg::RegObjSin, 48'h7fff_7fff_7fff);
    write_reg(vtp_pkg::RegCamCos, 48'h7fff_8000_7fff);
    write_reg(vtp_pkg::RegCamSin, 48'h8000_7fff_8000);
    write_reg(vtp_pkg::RegScale, 48'hffff_ffff_ffff);
    write_reg(vtp_pkg::RegOffset, 64'h7fff_ffff_ffff_ffff);
    write_reg(vtp_pkg::RegCenter, 64'hffff_ffff);
    queue_random(60, 1'b1);
    drain();
    write_reg(vtp_pkg::RegScale, 48'h8000_7fff_0000);
    write_reg(vtp_pkg::RegOffset, {1'b0, 21'h100000, 21'h0fffff, 21'h100000});
    write_reg(vtp_pkg::RegCenter, 64'h0);
    queue_random(60, 1'b1);
    drain();

    repeat (14) begin
      write_reg(vtp_pkg::RegObjCos, trig_triple(1'b1));
      write_reg(vtp_pkg::RegObjSin, trig_triple(1'b0));
      write_reg(vtp_pkg::RegCamCos, trig_triple(1'b1));
      write_reg(vtp_pkg::RegCamSin, trig_triple(1'b0));
      write_reg(vtp_pkg::RegScale, {16'($urandom_range(0, 1024)),
                                    16'($urandom_range(0, 1024)),
                                    ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'h0100});
      write_reg(vtp_pkg::RegOffset, {1'b0, 21'($urandom()), 21'($urandom()),
                                     21'($urandom_range(0, 1) ? $urandom() : 0)});
      write_reg(vtp_pkg::RegCenter, {$urandom()});
      queue_random(120, $urandom_range(0, 4) == 0);
      drain();
    end

    if (errors == 0) begin
      $display("vertex_transform_project_core verification clean");
    end else begin
      $display("vertex_transform_project_core verification failed");
    end
    $finish;
  end

endmodule
